### src/swsfr_pkg.sv
// Package with word types, phase codes and constants for the single-wire sensor frame reader.
package swsfr_pkg;

    localparam int unsigned TICK_W     = 15;
    localparam int unsigned LIMIT_W    = 8;
    localparam int unsigned BIT_IDX_W  = 6;
    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned HOLD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [BIT_IDX_W-1:0] FRAME_BITS = BIT_IDX_W'(FRAME_W);

    localparam logic [TICK_W-1:0]  START_LOW_RESET   = 15'd18000;
    localparam logic [LIMIT_W-1:0] THRESHOLD_RESET   = 8'd30;
    localparam logic [LIMIT_W-1:0] ACK_LOW_RESET     = 8'd40;
    localparam logic [LIMIT_W-1:0] ACK_PHASE_RESET   = 8'd90;
    localparam logic [LIMIT_W-1:0] BIT_GAP_RESET     = 8'd50;
    localparam logic [LIMIT_W-1:0] BIT_HIGH_RESET    = 8'd80;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_PHASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_START    = 7'b0000010,
        PH_ACK_LOW  = 7'b0000100,
        PH_ACK_HIGH = 7'b0001000,
        PH_ACK_END  = 7'b0010000,
        PH_BIT_GAP  = 7'b0100000,
        PH_BIT_HIGH = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic pin_level;
    } in_word_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] humidity_int;
        logic [7:0] humidity_dec;
        logic [7:0] temperature_int;
        logic [7:0] temperature_dec;
    } out_word_t;

endpackage

### src/single_wire_sensor_frame_reader.sv
// Each accepted input word has its result word registered in the output register.
// Throughput: one word per cycle; a new word is taken whenever the output register is
// empty or is being emptied in the same cycle, so the state update is the only loop.
// Reset (aresetn low, synchronous): phase idle, counters, frame and result bytes cleared,
// configuration registers back to their defaults, output register empty.
module single_wire_sensor_frame_reader (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  swsfr_pkg::in_word_t                     s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output swsfr_pkg::out_word_t                    m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [swsfr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [swsfr_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import swsfr_pkg::*;

    logic [TICK_W-1:0]    start_low_reg;
    logic [LIMIT_W-1:0]   threshold_reg;
    logic [LIMIT_W-1:0]   ack_low_reg;
    logic [LIMIT_W-1:0]   ack_phase_reg;
    logic [LIMIT_W-1:0]   bit_gap_reg;
    logic [LIMIT_W-1:0]   bit_high_reg;

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [HOLD_W-1:0]    hold_reg, hold_next;

    logic                 m_valid_reg;
    out_word_t            m_data_reg;

    logic                 in_accept;
    logic                 wait_target;
    logic [LIMIT_W-1:0]   wait_limit;
    logic                 done;
    logic [1:0]           status;
    logic                 data_bit;
    logic [BIT_IDX_W-1:0] bit_idx_inc;
    logic [FRAME_W-1:0]   frame_shifted;
    logic [7:0]           byte_sum;
    out_word_t            result;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_low_reg <= START_LOW_RESET;
            threshold_reg <= THRESHOLD_RESET;
            ack_low_reg   <= ACK_LOW_RESET;
            ack_phase_reg <= ACK_PHASE_RESET;
            bit_gap_reg   <= BIT_GAP_RESET;
            bit_high_reg  <= BIT_HIGH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_START_LOW: start_low_reg <= cfg_data[TICK_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[LIMIT_W-1:0];
                CFG_ACK_LOW:   ack_low_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_ACK_PHASE: ack_phase_reg <= cfg_data[LIMIT_W-1:0];
                CFG_BIT_GAP:   bit_gap_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_BIT_HIGH:  bit_high_reg  <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        wait_target = 1'b0;
        wait_limit  = ack_low_reg;
        unique case (phase_reg)
            PH_ACK_HIGH: begin
                wait_target = 1'b1;
                wait_limit  = ack_phase_reg;
            end
            PH_ACK_END: begin
                wait_target = 1'b0;
                wait_limit  = ack_phase_reg;
            end
            PH_BIT_GAP: begin
                wait_target = 1'b1;
                wait_limit  = bit_gap_reg;
            end
            PH_BIT_HIGH: begin
                wait_target = 1'b0;
                wait_limit  = bit_high_reg;
            end
            default: begin
                wait_target = 1'b0;
                wait_limit  = ack_low_reg;
            end
        endcase
    end

    assign data_bit      = (tick_reg >= TICK_W'(threshold_reg));
    assign bit_idx_inc   = bit_idx_reg + BIT_IDX_W'(1);
    assign frame_shifted = {frame_reg[FRAME_W-2:0], data_bit};
    assign byte_sum      = frame_shifted[39:32] + frame_shifted[31:24]
                         + frame_shifted[23:16] + frame_shifted[15:8];

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        frame_next   = frame_reg;
        hold_next    = hold_reg;
        done         = 1'b0;
        status       = ST_OK;
        unique case (phase_reg)
            PH_IDLE: begin
                if (s_data.start_req) begin
                    if (start_low_reg == '0) begin
                        phase_next = PH_ACK_LOW;
                        tick_next  = '0;
                    end else begin
                        phase_next = PH_START;
                        tick_next  = TICK_W'(1);
                    end
                end
            end
            PH_START: begin
                if (tick_reg >= start_low_reg) begin
                    phase_next = PH_ACK_LOW;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
            PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_END, PH_BIT_GAP, PH_BIT_HIGH: begin
                if (s_data.pin_level == wait_target) begin
                    tick_next = '0;
                    unique case (phase_reg)
                        PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
                        PH_ACK_HIGH: phase_next = PH_ACK_END;
                        PH_ACK_END: begin
                            phase_next   = PH_BIT_GAP;
                            bit_idx_next = '0;
                            frame_next   = '0;
                        end
                        PH_BIT_GAP:  phase_next = PH_BIT_HIGH;
                        default: begin
                            frame_next   = frame_shifted;
                            bit_idx_next = bit_idx_inc;
                            if (bit_idx_inc >= FRAME_BITS) begin
                                hold_next  = frame_shifted[FRAME_W-1:8];
                                done       = 1'b1;
                                status     = (byte_sum == frame_shifted[7:0]) ?
                                             ST_OK : ST_CHECKSUM;
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_BIT_GAP;
                            end
                        end
                    endcase
                end else if (tick_reg >= TICK_W'(wait_limit)) begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                    status     = ST_TIMEOUT;
                end else begin
                    tick_next = tick_reg + TICK_W'(1);
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_comb begin
        result.drive_low       = (phase_next == PH_START);
        result.busy_res        = (phase_next != PH_IDLE);
        result.done_res        = done;
        result.status          = done ? status : ST_OK;
        result.humidity_int    = hold_next[31:24];
        result.humidity_dec    = hold_next[23:16];
        result.temperature_int = hold_next[15:8];
        result.temperature_dec = hold_next[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            frame_reg   <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                bit_idx_reg <= bit_idx_next;
                frame_reg   <= frame_next;
                hold_reg    <= hold_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= result;
        end
    end

`ifndef SYNTH
    // A finished read never reports itself as still in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.done_res |-> !m_data_reg.busy_res)
        else $error("done word reports busy");

    // A status other than ok appears only on the word that ends a read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status != ST_OK) |-> m_data_reg.done_res)
        else $error("status set without done");

    // The line is driven only while a read is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.drive_low |-> m_data_reg.busy_res)
        else $error("line driven while idle");

    // An empty output register always lets the next word in.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

    // The state only moves on an accepted word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(phase_reg) && $stable(tick_reg))
        else $error("state changed without an accepted word");
`endif

endmodule
